// File: rtl/ble_pkg.sv
// Shared constants, codes and types of the bounded list engine.
`timescale 1ns / 1ps
`default_nettype none
package ble_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int ITEM_W      = 32;
  localparam int STORE_W     = (VALUE_WIDTH < ITEM_W) ? VALUE_WIDTH : ITEM_W;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int POS_W       = 8;
  localparam int SPAN_W      = ((CNT_W + 1) > POS_W) ? (CNT_W + 1) : POS_W;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_RANGE  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [STORE_W-1:0] wdata;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// File: rtl/ble_store.sv
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ble_store (
  input  wire logic                         clk_i,
  input  wire ble_pkg::mem_req_t            req_i,
  output logic [ble_pkg::STORE_W-1:0]       rdata_o
);

  logic [ble_pkg::STORE_W-1:0] mem_q [ble_pkg::DEPTH];
  logic [ble_pkg::STORE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: rtl/ble_seq.sv
// Request sequencer with the shared compare unit, fill count and result register.
`timescale 1ns / 1ps
`default_nettype none
module ble_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          allow_dup_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    req_type_i,
  input  wire logic [ble_pkg::ITEM_W-1:0]    item_value_i,
  input  wire logic signed [ble_pkg::POS_W-1:0] range_start_i,
  input  wire logic signed [ble_pkg::POS_W-1:0] range_end_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [2:0]                         status_o,
  output logic [ble_pkg::ITEM_W-1:0]         out_value_o,
  output logic [6:0]                         entry_count_o,
  output logic                               last_o,
  output ble_pkg::mem_req_t                  mem_req_o,
  input  wire logic [ble_pkg::STORE_W-1:0]   rdata_i
);

  localparam int IW = ble_pkg::IDX_W;
  localparam int CW = ble_pkg::CNT_W;
  localparam int SW = ble_pkg::SPAN_W;

  typedef enum logic [9:0] {
    S_IDLE       = 10'b00_0000_0001,
    S_SCAN_RD    = 10'b00_0000_0010,
    S_SCAN_CMP   = 10'b00_0000_0100,
    S_SHIFT_RD   = 10'b00_0000_1000,
    S_SHIFT_WR   = 10'b00_0001_0000,
    S_INS_FIN    = 10'b00_0010_0000,
    S_RANGE_SET  = 10'b00_0100_0000,
    S_RANGE_RD   = 10'b00_1000_0000,
    S_RANGE_EMIT = 10'b01_0000_0000,
    S_RESP       = 10'b10_0000_0000
  } state_e;

  state_e                        state_q, state_d;
  ble_pkg::req_e                 req_q, req_d;
  ble_pkg::status_e              status_q, status_d;
  logic [ble_pkg::STORE_W-1:0]   val_q, val_d;
  logic signed [ble_pkg::POS_W-1:0] start_q, start_d, stop_q, stop_d;
  logic [IW-1:0]                 ptr_q, ptr_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [CW-1:0]                 end_q, end_d;

  logic                          out_valid_q, out_valid_d;
  ble_pkg::status_e              out_status_q, out_status_d;
  logic [ble_pkg::ITEM_W-1:0]    out_value_q, out_value_d;
  logic [CW-1:0]                 out_count_q, out_count_d;
  logic                          out_last_q, out_last_d;
  logic                          out_load;
  logic                          out_free;

  logic [CW-1:0]                 ptr_nx;
  logic                          more;
  logic                          hit;
  logic signed [SW-1:0]          s_w, e_w, c_w, s_cl, e_cl;
  logic                          range_empty;
  logic                          emit_last;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign ptr_nx    = CW'(ptr_q) + CW'(1);
  assign more      = ptr_nx < cnt_q;
  assign hit       = (rdata_i == val_q);
  assign emit_last = (ptr_nx == end_q);

  assign s_w  = SW'(start_q);
  assign e_w  = SW'(stop_q);
  assign c_w  = signed'(SW'(cnt_q));
  assign s_cl = s_w[SW-1] ? '0 : s_w;
  assign e_cl = (e_w > c_w) ? c_w : e_w;
  assign range_empty = (s_w >= c_w) || e_w[SW-1] || (s_cl >= e_cl);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    status_d     = status_q;
    val_d        = val_q;
    start_d      = start_q;
    stop_d       = stop_q;
    ptr_d        = ptr_q;
    cnt_d        = cnt_q;
    end_d        = end_q;
    out_load     = 1'b0;
    out_status_d = ble_pkg::ST_OK;
    out_value_d  = '0;
    out_last_d   = 1'b1;
    mem_req_o    = '{we: 1'b0, waddr: '0, wdata: val_q, raddr: ptr_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = ble_pkg::req_e'(req_type_i);
          val_d   = ble_pkg::STORE_W'(item_value_i);
          start_d = range_start_i;
          stop_d  = range_end_i;
          ptr_d   = '0;
          case (ble_pkg::req_e'(req_type_i))
            ble_pkg::REQ_INSERT: begin
              state_d = (!allow_dup_i && cnt_q != '0) ? S_SCAN_RD : S_INS_FIN;
            end
            ble_pkg::REQ_REMOVE: begin
              if (cnt_q != '0) begin
                state_d = S_SCAN_RD;
              end else begin
                status_d = ble_pkg::ST_NOTFOUND;
                state_d  = S_RESP;
              end
            end
            ble_pkg::REQ_RANGE: begin
              state_d = S_RANGE_SET;
            end
            default: begin
              status_d = ble_pkg::ST_OK;
              state_d  = S_RESP;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (hit) begin
          if (req_q == ble_pkg::REQ_INSERT) begin
            status_d = ble_pkg::ST_DUP;
            state_d  = S_RESP;
          end else if (more) begin
            ptr_d   = IW'(ptr_nx);
            state_d = S_SHIFT_RD;
          end else begin
            cnt_d    = cnt_q - CW'(1);
            status_d = ble_pkg::ST_OK;
            state_d  = S_RESP;
          end
        end else if (more) begin
          ptr_d   = IW'(ptr_nx);
          state_d = S_SCAN_RD;
        end else if (req_q == ble_pkg::REQ_INSERT) begin
          state_d = S_INS_FIN;
        end else begin
          status_d = ble_pkg::ST_NOTFOUND;
          state_d  = S_RESP;
        end
      end
      S_SHIFT_RD: begin
        state_d = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = ptr_q - IW'(1);
        mem_req_o.wdata = rdata_i;
        if (more) begin
          ptr_d   = IW'(ptr_nx);
          state_d = S_SHIFT_RD;
        end else begin
          cnt_d    = cnt_q - CW'(1);
          status_d = ble_pkg::ST_OK;
          state_d  = S_RESP;
        end
      end
      S_INS_FIN: begin
        if (cnt_q >= CW'(ble_pkg::DEPTH)) begin
          status_d = ble_pkg::ST_FULL;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = cnt_q[IW-1:0];
          cnt_d           = cnt_q + CW'(1);
          status_d        = ble_pkg::ST_OK;
        end
        state_d = S_RESP;
      end
      S_RANGE_SET: begin
        if (range_empty) begin
          status_d = ble_pkg::ST_EMPTY;
          state_d  = S_RESP;
        end else begin
          ptr_d   = s_cl[IW-1:0];
          end_d   = e_cl[CW-1:0];
          state_d = S_RANGE_RD;
        end
      end
      S_RANGE_RD: begin
        state_d = S_RANGE_EMIT;
      end
      S_RANGE_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ble_pkg::ST_OK;
          out_value_d  = ble_pkg::ITEM_W'(rdata_i);
          out_last_d   = emit_last;
          if (emit_last) begin
            state_d = S_IDLE;
          end else begin
            ptr_d   = IW'(ptr_nx);
            state_d = S_RANGE_RD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_count_d = cnt_q;
  assign out_valid_d = out_load ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    status_q <= status_d;
    val_q    <= val_d;
    start_q  <= start_d;
    stop_q   <= stop_d;
    ptr_q    <= ptr_d;
    end_q    <= end_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign out_value_o   = out_value_q;
  assign entry_count_o = 7'(out_count_q);
  assign last_o        = out_last_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(ble_pkg::DEPTH))
    else $error("fill count above depth");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("accepted word left sequencer idle");

  a_mid_range_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !out_last_d) |=> (state_q == S_RANGE_RD))
    else $error("range walk stopped before last word");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_FIN && cnt_q < CW'(ble_pkg::DEPTH))
      |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not grow fill count");

  a_write_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (CW'(mem_req_o.waddr) < cnt_q + CW'(1)))
    else $error("entry write outside filled region");
`endif

endmodule
`default_nettype wire

// File: rtl/bounded_list_engine.sv
// Top level of the bounded list engine: configuration register, sequencer and storage.
`timescale 1ns / 1ps
`default_nettype none
// Bounded ordered list of up to 64 words with a fill count. One request word is
// taken at a time; in_stall_o stays high until the request's last result word has
// been loaded into the output register. All work goes through one registered read
// port of the entry storage and one 32-bit compare. Insert with duplicates
// disallowed first scans the list; remove searches, then shifts the later entries.
// Range read emits one word per entry in the range. Every request takes longer
// while the output side stalls. Results carry last_o = 1 on the final word of a
// request. allow_duplicates resets to 1; the user must write it through cfg_we_i
// only while idle, as the block itself does not enforce this.
module bounded_list_engine (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic                              cfg_wdata_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic [31:0]                       item_value_i,
  input  wire logic signed [7:0]                 range_start_i,
  input  wire logic signed [7:0]                 range_end_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [2:0]                             status_o,
  output logic [31:0]                            out_value_o,
  output logic [6:0]                             entry_count_o,
  output logic                                   last_o
);

  logic                          allow_dup_q, allow_dup_d;
  ble_pkg::mem_req_t             mem_req;
  logic [ble_pkg::STORE_W-1:0]   rdata;

  assign allow_dup_d = cfg_we_i ? cfg_wdata_i : allow_dup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_dup_q <= 1'b1;
    end else begin
      allow_dup_q <= allow_dup_d;
    end
  end

  ble_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .allow_dup_i   (allow_dup_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .item_value_i  (item_value_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o),
    .mem_req_o     (mem_req),
    .rdata_i       (rdata)
  );

  ble_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for bounded_list_engine: directed rows, then randomized phases.
`timescale 1ns / 1ps
module tb;
  import ble_pkg::*;

  typedef struct {
    logic    is_cfg;
    req_e    req;
    logic [31:0] val;
    logic signed [7:0] from;
    logic signed [7:0] upto;
    logic    typed;
    status_e st;
    logic [6:0] cnt;
  } row_t;

  typedef struct {
    status_e     st;
    logic [31:0] val;
    logic [6:0]  cnt;
    logic        last;
  } word_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_wdata_i   = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [1:0]        req_type_i    = 2'd0;
  logic [31:0]       item_value_i  = 32'd0;
  logic signed [7:0] range_start_i = 8'sd0;
  logic signed [7:0] range_end_i   = 8'sd0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [2:0]        status_o;
  logic [31:0]       out_value_o;
  logic [6:0]        entry_count_o;
  logic              last_o;

  bounded_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .item_value_i  (item_value_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .out_value_o   (out_value_o),
    .entry_count_o (entry_count_o),
    .last_o        (last_o)
  );

  logic [31:0] shadow_list [DEPTH];
  int          shadow_count = 0;
  logic        dups_ok      = 1'b1;
  word_t       words_due [$];
  logic [31:0] pool [8];

  int snd_pct       = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int errors        = 0;
  int requests_sent = 0;
  int words_seen    = 0;
  int status_seen [5] = '{0, 0, 0, 0, 0};
  word_t want;

  row_t script [24] = '{
    '{1'b0, REQ_RANGE,  32'd0,         8'sd0,   8'sd10,  1'b1, ST_EMPTY,    7'd0},
    '{1'b0, REQ_REMOVE, 32'd5,         8'sd0,   8'sd0,   1'b1, ST_NOTFOUND, 7'd0},
    '{1'b0, REQ_INSERT, 32'd0,         8'sd0,   8'sd0,   1'b1, ST_OK,       7'd1},
    '{1'b0, REQ_INSERT, 32'hFFFF_FFFF, 8'sd0,   8'sd0,   1'b1, ST_OK,       7'd2},
    '{1'b0, REQ_INSERT, 32'hFFFF_FFFF, 8'sd0,   8'sd0,   1'b1, ST_OK,       7'd3},
    '{1'b0, REQ_INSERT, 32'h8000_0001, 8'sd0,   8'sd0,   1'b1, ST_OK,       7'd4},
    '{1'b0, REQ_INSERT, 32'h7FFF_FFFE, 8'sd0,   8'sd0,   1'b1, ST_OK,       7'd5},
    '{1'b0, REQ_RANGE,  32'd0,         8'sh80,  8'sd127, 1'b0, ST_OK,       7'd0},
    '{1'b0, REQ_RANGE,  32'd0,         8'sd127, 8'sh80,  1'b1, ST_EMPTY,    7'd5},
    '{1'b0, REQ_RANGE,  32'd0,         8'sd2,   8'sd2,   1'b1, ST_EMPTY,    7'd5},
    '{1'b0, REQ_RANGE,  32'd0,         -8'sd1,  8'sd1,   1'b0, ST_OK,       7'd0},
    '{1'b0, REQ_RANGE,  32'd0,         8'sd4,   8'sd5,   1'b0, ST_OK,       7'd0},
    '{1'b0, REQ_RANGE,  32'd0,         8'sd5,   8'sd10,  1'b1, ST_EMPTY,    7'd5},
    '{1'b0, REQ_RANGE,  32'd0,         8'sd0,   -8'sd1,  1'b1, ST_EMPTY,    7'd5},
    '{1'b0, REQ_NONE,   32'd123,       8'sd3,   8'sd4,   1'b1, ST_OK,       7'd5},
    '{1'b1, REQ_NONE,   32'd0,         8'sd0,   8'sd0,   1'b0, ST_OK,       7'd0},
    '{1'b0, REQ_INSERT, 32'hFFFF_FFFF, 8'sd0,   8'sd0,   1'b1, ST_DUP,      7'd5},
    '{1'b0, REQ_INSERT, 32'h1234_5678, 8'sd0,   8'sd0,   1'b1, ST_OK,       7'd6},
    '{1'b0, REQ_REMOVE, 32'hFFFF_FFFF, 8'sd0,   8'sd0,   1'b1, ST_OK,       7'd5},
    '{1'b0, REQ_REMOVE, 32'hDEAD_BEEF, 8'sd0,   8'sd0,   1'b1, ST_NOTFOUND, 7'd5},
    '{1'b0, REQ_RANGE,  32'd0,         8'sd0,   8'sd127, 1'b0, ST_OK,       7'd0},
    '{1'b0, REQ_REMOVE, 32'd0,         8'sd0,   8'sd0,   1'b1, ST_OK,       7'd4},
    '{1'b0, REQ_RANGE,  32'd0,         -8'sd5,  8'sd3,   1'b0, ST_OK,       7'd0},
    '{1'b1, REQ_NONE,   32'd1,         8'sd0,   8'sd0,   1'b0, ST_OK,       7'd0}
  };

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void due(status_e st, logic [31:0] v, logic last);
    words_due.push_back('{st, v, shadow_count[6:0], last});
  endfunction

  // Apply one request to the shadow list and queue the result words it causes.
  task automatic list_apply(req_e req, logic [31:0] v, logic signed [7:0] from,
                            logic signed [7:0] upto);
    int hit, lo, hi;
    hit = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_list[i] == v) hit = i;
    lo = int'(from);
    hi = int'(upto);
    case (req)
      REQ_INSERT: begin
        if (!dups_ok && hit >= 0) begin
          due(ST_DUP, 32'd0, 1'b1);
        end else if (shadow_count >= DEPTH) begin
          due(ST_FULL, 32'd0, 1'b1);
        end else begin
          shadow_list[shadow_count] = v;
          shadow_count++;
          due(ST_OK, 32'd0, 1'b1);
        end
      end
      REQ_REMOVE: begin
        if (hit < 0) begin
          due(ST_NOTFOUND, 32'd0, 1'b1);
        end else begin
          for (int i = hit; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
          shadow_count--;
          due(ST_OK, 32'd0, 1'b1);
        end
      end
      REQ_RANGE: begin
        if (lo >= shadow_count || hi < 0) begin
          due(ST_EMPTY, 32'd0, 1'b1);
        end else begin
          if (lo < 0) lo = 0;
          if (hi > shadow_count) hi = shadow_count;
          if (lo >= hi) begin
            due(ST_EMPTY, 32'd0, 1'b1);
          end else begin
            for (int k = lo; k < hi; k++) due(ST_OK, shadow_list[k], k == hi - 1);
          end
        end
      end
      default: due(ST_OK, 32'd0, 1'b1);
    endcase
  endtask

  // Offer one request word, hold it until accepted, then queue its results.
  task automatic send_request(req_e r, logic [31:0] v, logic signed [7:0] a,
                              logic signed [7:0] b, logic typed, status_e st,
                              logic [6:0] cnt);
    int n0;
    while (snd_pct != 0 && $urandom_range(0, 99) < snd_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= r;
    item_value_i  <= v;
    range_start_i <= a;
    range_end_i   <= b;
    do @(posedge clk_i); while (in_stall_o);
    requests_sent++;
    n0 = words_due.size();
    list_apply(r, v, a, b);
    if (typed) begin
      while (words_due.size() > n0) void'(words_due.pop_back());
      words_due.push_back('{st, 32'd0, cnt, 1'b1});
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_dups(logic v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dups_ok = v;
  endtask

  function automatic logic [31:0] some_value(int stored_pct);
    if (shadow_count > 0 && $urandom_range(0, 99) < stored_pct)
      return shadow_list[$urandom_range(0, shadow_count - 1)];
    if ($urandom_range(0, 1)) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic send_random(int ins, int rem, int rng);
    int roll, lo;
    logic signed [7:0] a, b;
    roll = $urandom_range(0, 99);
    a = 8'($urandom);
    b = 8'($urandom);
    if (roll < ins) begin
      send_request(REQ_INSERT, some_value(dups_ok ? 10 : 35), a, b, 1'b0, ST_OK, 7'd0);
    end else if (roll < ins + rem) begin
      send_request(REQ_REMOVE, some_value(70), a, b, 1'b0, ST_OK, 7'd0);
    end else if (roll < ins + rem + rng) begin
      case ($urandom_range(0, 7))
        0, 1: ;
        2: begin
          a = 8'sh80;
          b = 8'sd127;
        end
        default: begin
          lo = $urandom_range(0, shadow_count + 2) - 2;
          a = 8'(lo);
          b = 8'(lo + $urandom_range(0, 12) - 1);
        end
      endcase
      send_request(REQ_RANGE, $urandom, a, b, 1'b0, ST_OK, 7'd0);
    end else begin
      send_request(REQ_NONE, $urandom, a, b, 1'b0, ST_OK, 7'd0);
    end
  endtask

  task automatic run_phase(int n, logic dups, int snd, int rcv, int ins, int rem, int rng,
                           logic hold);
    set_dups(dups);
    snd_pct = snd;
    stall_pct <= rcv;
    if (hold) hold_requests <= hold_requests + 1;
    repeat (n) send_random(ins, rem, rng);
  endtask

  function automatic void note_mismatch(string what);
    errors++;
    if (errors <= 10)
      $display("[%0t] mismatch, %s: expected %0d/%h/%0d/%0b, got %0d/%h/%0d/%0b",
               $realtime, what, want.st, want.val, want.cnt, want.last,
               status_o, out_value_o, entry_count_o, last_o);
  endfunction

  // Check each accepted result word; drive the receiver stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      words_seen++;
      if (status_o < 3'd5) status_seen[status_o]++;
      if (words_due.size() == 0) begin
        want = '{ST_OK, 32'd0, 7'd0, 1'b0};
        note_mismatch("no result pending");
      end else begin
        want = words_due.pop_front();
        if (status_o !== want.st || out_value_o !== want.val ||
            entry_count_o !== want.cnt || last_o !== want.last)
          note_mismatch("field differs");
      end
    end
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    pool[0] = 32'd0;
    pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) pool[i] = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        set_dups(script[i].val[0]);
      end else begin
        send_request(script[i].req, script[i].val, script[i].from, script[i].upto,
                     script[i].typed, script[i].st, script[i].cnt);
      end
    end

    run_phase(75, 1'b1, 0,  0,  95, 0,  4,  1'b0);
    run_phase(20, 1'b0, 59, 0,  45, 20, 30, 1'b0);
    run_phase(25, 1'b0, 0,  59, 25, 45, 25, 1'b0);
    run_phase(25, 1'b1, 9,  9,  35, 30, 30, 1'b0);
    run_phase(20, 1'b0, 0,  0,  40, 25, 30, 1'b1);
    run_phase(15, 1'b1, 59, 0,  35, 30, 30, 1'b0);

    drain();
    repeat (20) @(posedge clk_i);
    $display("Ran %0d requests, %0d result words, six idle/stall mixes, both dup modes.",
             requests_sent, words_seen);
    $display("Rejections: %0d duplicate, %0d full, %0d not found, %0d empty; %0d mismatches.",
             status_seen[1], status_seen[2], status_seen[3], status_seen[4], errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
